// ===== rtl/core/si_pkg.sv =====
// Shared widths, payload types and inter-stage structs for the segment intersection block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package si_pkg;

  localparam int unsigned COORD_BITS      = 16;
  localparam int unsigned PARAM_FRAC_BITS = 16;

  // endpoint differences, cross-product terms and their difference
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  // magnitude of the normalized denominator and numerators
  localparam int unsigned MAG_W   = PROD_W;
  // quotient bits cover both the parameter (Q1.FB) and the point offset
  localparam int unsigned QUO_W   =
      (COORD_BITS > PARAM_FRAC_BITS ? COORD_BITS : PARAM_FRAC_BITS) + 1;
  localparam int unsigned NUM_W   = MAG_W + QUO_W;
  localparam int unsigned SPLIT_W = MAG_W / 2;
  // front end 4, partial products 2, divider QUO_W, output 1
  localparam int unsigned LATENCY = QUO_W + 7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } si_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
    logic [PARAM_FRAC_BITS:0]     t_frac;
    logic [PARAM_FRAC_BITS:0]     u_frac;
  } si_out_t;

  // front end result: normalized cross products and point terms
  typedef struct packed {
    logic                         valid;
    logic                         hit;
    logic [MAG_W-1:0]             den;
    logic [MAG_W-1:0]             tn;
    logic [MAG_W-1:0]             un;
    logic [COORD_BITS-1:0]        rx_mag;
    logic                         rx_neg;
    logic [COORD_BITS-1:0]        ry_mag;
    logic                         ry_neg;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } si_front_t;

  // fields that ride alongside the divider lanes
  typedef struct packed {
    logic                         valid;
    logic                         hit;
    logic                         rx_neg;
    logic                         ry_neg;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } si_side_t;

endpackage

// ===== rtl/core/si_div.sv =====
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on si_pkg for widths; the numerator's top MAG_W bits must be below the divisor.
module si_div (
  input  logic                     clk,
  input  logic [si_pkg::NUM_W-1:0] num,
  input  logic [si_pkg::MAG_W-1:0] den,
  output logic [si_pkg::QUO_W-1:0] quo,
  output logic                     rem_nz
);

  localparam int unsigned QW = si_pkg::QUO_W;
  localparam int unsigned MW = si_pkg::MAG_W;
  localparam int unsigned NW = si_pkg::NUM_W;

  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [MW-1:0] den_r  [QW-1];
  logic [QW-1:0] low_r  [QW-1];

  logic [MW-1:0] rem_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [MW-1:0] den_in [QW];
  logic [QW-1:0] low_in [QW];
  logic [MW+1:0] diff   [QW];

  always_comb begin
    rem_in[0] = num[NW-1:QW];
    quo_in[0] = '0;
    den_in[0] = den;
    low_in[0] = num[QW-1:0];
    for (int i = 1; i < QW; i++) begin
      rem_in[i] = rem_r[i-1];
      quo_in[i] = quo_r[i-1];
      den_in[i] = den_r[i-1];
      low_in[i] = low_r[i-1];
    end
    // trial subtract of the divisor from the partial remainder with the next bit in
    for (int i = 0; i < QW; i++) begin
      diff[i] = {1'b0, rem_in[i], low_in[i][QW-1]} - {2'b00, den_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW - 1; i++) begin
      den_r[i] <= den_in[i];
      low_r[i] <= {low_in[i][QW-2:0], 1'b0};
    end
    for (int i = 0; i < QW; i++) begin
      if (diff[i][MW+1]) begin
        rem_r[i] <= {rem_in[i][MW-2:0], low_in[i][QW-1]};
        quo_r[i] <= {quo_in[i][QW-2:0], 1'b0};
      end else begin
        rem_r[i] <= diff[i][MW-1:0];
        quo_r[i] <= {quo_in[i][QW-2:0], 1'b1};
      end
    end
  end

  assign quo    = quo_r[QW-1];
  assign rem_nz = |rem_r[QW-1];

endmodule

// ===== rtl/core/si_front.sv =====
// Geometry front end: bounding-box test, differences, cross products, sign normalization.
// Four register stages; depends on si_pkg for payload and result structs.
module si_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  si_pkg::si_in_t    in_data,
  output si_pkg::si_front_t front
);

  localparam int unsigned CW = si_pkg::COORD_BITS;
  localparam int unsigned DW = si_pkg::DIFF_W;
  localparam int unsigned PW = si_pkg::PROD_W;
  localparam int unsigned XW = si_pkg::CROSS_W;
  localparam int unsigned MW = si_pkg::MAG_W;

  // ---- stage A: box test and differences
  logic signed [CW-1:0] px, py, ex, ey, qx, qy, fx, fy;
  logic signed [CW-1:0] p_xlo, p_xhi, p_ylo, p_yhi, q_xlo, q_xhi, q_ylo, q_yhi;
  logic                 a_box_nxt;

  logic                 a_valid_r, a_box_r;
  logic signed [DW-1:0] a_rx_r, a_ry_r, a_sx_r, a_sy_r, a_dx_r, a_dy_r;
  logic signed [CW-1:0] a_px_r, a_py_r;

  always_comb begin
    px = in_data.first_start_x;
    py = in_data.first_start_y;
    ex = in_data.first_end_x;
    ey = in_data.first_end_y;
    qx = in_data.second_start_x;
    qy = in_data.second_start_y;
    fx = in_data.second_end_x;
    fy = in_data.second_end_y;
    p_xlo = (px < ex) ? px : ex;
    p_xhi = (px < ex) ? ex : px;
    p_ylo = (py < ey) ? py : ey;
    p_yhi = (py < ey) ? ey : py;
    q_xlo = (qx < fx) ? qx : fx;
    q_xhi = (qx < fx) ? fx : qx;
    q_ylo = (qy < fy) ? qy : fy;
    q_yhi = (qy < fy) ? fy : qy;
    // boxes that only touch still overlap
    a_box_nxt = !((p_xlo > q_xhi) || (p_xhi < q_xlo) ||
                  (p_ylo > q_yhi) || (p_yhi < q_ylo));
  end

  always_ff @(posedge clk) begin
    a_box_r <= a_box_nxt;
    a_rx_r  <= DW'(ex) - DW'(px);
    a_ry_r  <= DW'(ey) - DW'(py);
    a_sx_r  <= DW'(fx) - DW'(qx);
    a_sy_r  <= DW'(fy) - DW'(qy);
    a_dx_r  <= DW'(qx) - DW'(px);
    a_dy_r  <= DW'(qy) - DW'(py);
    a_px_r  <= px;
    a_py_r  <= py;
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  // ---- stage B: the six cross-product terms
  logic                 b_valid_r, b_box_r;
  logic signed [PW-1:0] b_p0_r, b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r;
  logic signed [DW-1:0] b_rx_r, b_ry_r;
  logic signed [CW-1:0] b_px_r, b_py_r;

  always_ff @(posedge clk) begin
    b_box_r <= a_box_r;
    b_p0_r  <= PW'(a_rx_r) * PW'(a_sy_r);
    b_p1_r  <= PW'(a_ry_r) * PW'(a_sx_r);
    b_p2_r  <= PW'(a_dx_r) * PW'(a_sy_r);
    b_p3_r  <= PW'(a_dy_r) * PW'(a_sx_r);
    b_p4_r  <= PW'(a_dx_r) * PW'(a_ry_r);
    b_p5_r  <= PW'(a_dy_r) * PW'(a_rx_r);
    b_rx_r  <= a_rx_r;
    b_ry_r  <= a_ry_r;
    b_px_r  <= a_px_r;
    b_py_r  <= a_py_r;
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  // ---- stage C: cross products and direction magnitudes
  logic                 c_valid_r, c_box_r;
  logic signed [XW-1:0] c_den_r, c_tn_r, c_un_r;
  logic [CW-1:0]        c_rx_mag_r, c_ry_mag_r;
  logic                 c_rx_neg_r, c_ry_neg_r;
  logic signed [CW-1:0] c_px_r, c_py_r;
  logic [DW-1:0]        rx_abs, ry_abs;

  always_comb begin
    rx_abs = b_rx_r[DW-1] ? DW'(-b_rx_r) : DW'(b_rx_r);
    ry_abs = b_ry_r[DW-1] ? DW'(-b_ry_r) : DW'(b_ry_r);
  end

  always_ff @(posedge clk) begin
    c_box_r    <= b_box_r;
    c_den_r    <= XW'(b_p0_r) - XW'(b_p1_r);
    c_tn_r     <= XW'(b_p2_r) - XW'(b_p3_r);
    c_un_r     <= XW'(b_p4_r) - XW'(b_p5_r);
    c_rx_mag_r <= rx_abs[CW-1:0];
    c_ry_mag_r <= ry_abs[CW-1:0];
    c_rx_neg_r <= b_rx_r[DW-1];
    c_ry_neg_r <= b_ry_r[DW-1];
    c_px_r     <= b_px_r;
    c_py_r     <= b_py_r;
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  // ---- stage D: range checks against the signed denominator, normalize signs
  logic                 den_neg, den_zero, t_ok, u_ok;
  logic signed [XW-1:0] den_flip, tn_flip, un_flip;
  si_pkg::si_front_t    front_nxt;
  si_pkg::si_front_t    front_r;

  always_comb begin
    den_neg  = c_den_r[XW-1];
    den_zero = (c_den_r == '0);
    // compare in the denominator's own sign so no negate sits before the compare
    t_ok = den_neg ? ((c_tn_r[XW-1] || (c_tn_r == '0)) && (c_tn_r >= c_den_r))
                   : (!c_tn_r[XW-1] && (c_tn_r <= c_den_r));
    u_ok = den_neg ? ((c_un_r[XW-1] || (c_un_r == '0)) && (c_un_r >= c_den_r))
                   : (!c_un_r[XW-1] && (c_un_r <= c_den_r));
    den_flip = den_neg ? -c_den_r : c_den_r;
    tn_flip  = den_neg ? -c_tn_r  : c_tn_r;
    un_flip  = den_neg ? -c_un_r  : c_un_r;

    front_nxt.valid  = c_valid_r;
    front_nxt.hit    = c_box_r && !den_zero && t_ok && u_ok;
    front_nxt.den    = den_flip[MW-1:0];
    front_nxt.tn     = tn_flip[MW-1:0];
    front_nxt.un     = un_flip[MW-1:0];
    front_nxt.rx_mag = c_rx_mag_r;
    front_nxt.rx_neg = c_rx_neg_r;
    front_nxt.ry_mag = c_ry_mag_r;
    front_nxt.ry_neg = c_ry_neg_r;
    front_nxt.px     = c_px_r;
    front_nxt.py     = c_py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// Pipeline: each pair taken on start passes the divider's QUO_W stages plus 7 stages of
// geometry, products and output before its result strobes on out_valid (si_pkg::LATENCY).
// Throughput: one segment pair per clock; busy stays low and the pipeline never stalls,
// as the receiver takes every result in its strobe cycle.
// Reset (rst_n low, synchronous) clears every stage's valid bit; in-flight pairs are dropped.
// Depends on si_pkg, si_front and si_div.
module segment_intersection (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  si_pkg::si_in_t  in_data,
  output logic            out_valid,
  output si_pkg::si_out_t out_data
);

  localparam int unsigned CW   = si_pkg::COORD_BITS;
  localparam int unsigned FB   = si_pkg::PARAM_FRAC_BITS;
  localparam int unsigned MW   = si_pkg::MAG_W;
  localparam int unsigned QW   = si_pkg::QUO_W;
  localparam int unsigned NW   = si_pkg::NUM_W;
  localparam int unsigned SW   = si_pkg::SPLIT_W;
  localparam int unsigned LO_W = CW + SW;
  localparam int unsigned HI_W = CW + MW - SW;

  // ---- geometry front end
  si_pkg::si_front_t front;

  si_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_data  (in_data),
    .front    (front)
  );

  // ---- stage E: partial products of |r| and tn, split over the tn halves
  si_pkg::si_side_t e_side_nxt, e_side_r;
  logic [MW-1:0]    e_den_r, e_tn_r, e_un_r;
  logic [LO_W-1:0]  e_xlo_r, e_ylo_r;
  logic [HI_W-1:0]  e_xhi_r, e_yhi_r;

  always_comb begin
    e_side_nxt.valid  = front.valid;
    e_side_nxt.hit    = front.hit;
    e_side_nxt.rx_neg = front.rx_neg;
    e_side_nxt.ry_neg = front.ry_neg;
    e_side_nxt.px     = front.px;
    e_side_nxt.py     = front.py;
  end

  always_ff @(posedge clk) begin
    e_den_r  <= front.den;
    e_tn_r   <= front.tn;
    e_un_r   <= front.un;
    e_xlo_r  <= LO_W'(front.rx_mag) * LO_W'(front.tn[SW-1:0]);
    e_xhi_r  <= HI_W'(front.rx_mag) * HI_W'(front.tn[MW-1:SW]);
    e_ylo_r  <= LO_W'(front.ry_mag) * LO_W'(front.tn[SW-1:0]);
    e_yhi_r  <= HI_W'(front.ry_mag) * HI_W'(front.tn[MW-1:SW]);
    if (!rst_n) begin
      e_side_r.valid <= 1'b0;
    end else begin
      e_side_r <= e_side_nxt;
    end
  end

  // ---- stage F: divider numerators
  si_pkg::si_side_t f_side_r;
  logic [MW-1:0]    f_den_r;
  logic [NW-1:0]    f_num_x_r, f_num_y_r, f_num_t_r, f_num_u_r;

  always_ff @(posedge clk) begin
    f_den_r   <= e_den_r;
    f_num_x_r <= (NW'(e_xhi_r) << SW) + NW'(e_xlo_r);
    f_num_y_r <= (NW'(e_yhi_r) << SW) + NW'(e_ylo_r);
    f_num_t_r <= NW'(e_tn_r) << FB;
    f_num_u_r <= NW'(e_un_r) << FB;
    if (!rst_n) begin
      f_side_r.valid <= 1'b0;
    end else begin
      f_side_r <= e_side_r;
    end
  end

  // ---- divider lanes and their sideband
  logic [QW-1:0] quo_x, quo_y, quo_t, quo_u;
  logic          rnz_x, rnz_y;

  si_div u_div_x (.clk(clk), .num(f_num_x_r), .den(f_den_r), .quo(quo_x), .rem_nz(rnz_x));
  si_div u_div_y (.clk(clk), .num(f_num_y_r), .den(f_den_r), .quo(quo_y), .rem_nz(rnz_y));
  si_div u_div_t (.clk(clk), .num(f_num_t_r), .den(f_den_r), .quo(quo_t), .rem_nz());
  si_div u_div_u (.clk(clk), .num(f_num_u_r), .den(f_den_r), .quo(quo_u), .rem_nz());

  si_pkg::si_side_t side_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0] <= f_side_r;
      for (int i = 1; i < QW; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---- output stage: signed floor of the offset, add the start point
  si_pkg::si_side_t side_end;
  logic [CW-1:0]    x_add, y_add, x_sum, y_sum;
  logic             x_cin, y_cin;
  si_pkg::si_out_t  out_nxt, out_data_r;
  logic             out_valid_r;

  always_comb begin
    side_end = side_r[QW-1];
    // floor(-q') = -q - 1 + (exact ? 1 : 0) = ~q + (exact ? 1 : 0)
    x_add = side_end.rx_neg ? ~quo_x[CW-1:0] : quo_x[CW-1:0];
    y_add = side_end.ry_neg ? ~quo_y[CW-1:0] : quo_y[CW-1:0];
    x_cin = side_end.rx_neg && !rnz_x;
    y_cin = side_end.ry_neg && !rnz_y;
    x_sum = side_end.px + x_add + CW'(x_cin);
    y_sum = side_end.py + y_add + CW'(y_cin);

    out_nxt.hit     = side_end.hit;
    out_nxt.cross_x = side_end.hit ? x_sum : '0;
    out_nxt.cross_y = side_end.hit ? y_sum : '0;
    out_nxt.t_frac  = side_end.hit ? quo_t[FB:0] : '0;
    out_nxt.u_frac  = side_end.hit ? quo_u[FB:0] : '0;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_end.valid;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions
  localparam int unsigned Lat = si_pkg::LATENCY;
  localparam logic [FB:0] ParamOne = {1'b1, {FB{1'b0}}};

  ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Lat))
    else $error("result strobe without a transaction at the pipeline latency");

  ap_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (out_data.t_frac <= ParamOne) &&
                                    (out_data.u_frac <= ParamOne))
    else $error("hit with a parameter above one");

  ap_front_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (front.valid && front.hit) |-> (front.den != '0) && (front.tn <= front.den) &&
                                   (front.un <= front.den))
    else $error("front end flagged a hit outside the normalized range");

  ap_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

// ===== test/tb_segment_intersection.sv =====
`timescale 1ns / 1ps
// Self-checking bench for segment_intersection: a directed table of segment pairs, then
// random pairs in several sender-idle phases. Typed rows are checked against their own
// table results, the others against an in-bench model. Depends on si_pkg and the RTL.
module tb_segment_intersection;

  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_PAIRS = 2000;
  localparam int PHASES       = 4;
  localparam int QUIET_LIMIT  = 2000;

  typedef logic signed [si_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [si_pkg::PARAM_FRAC_BITS:0]     frac_t;

  typedef struct {
    si_pkg::si_in_t  pair;
    bit              typed;
    si_pkg::si_out_t want;
  } pair_row_t;

  localparam si_pkg::si_out_t MISS = '0;

  logic            clk     = 1'b0;
  logic            rst_n   = 1'b0;
  logic            start   = 1'b0;
  logic            busy;
  si_pkg::si_in_t  in_data = '0;
  logic            out_valid;
  si_pkg::si_out_t out_data;

  si_pkg::si_out_t crossing_q[$];
  pair_row_t       directed_rows[$];
  int              mismatch_count = 0;
  int              quiet_cycles   = 0;
  int              idle_pct       = 0;
  int              phase_idle[PHASES] = '{0, 70, 0, 34};

  segment_intersection uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic longint lo2(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // floor(comp * num / den) for den > 0
  function automatic longint floor_scale(longint comp, longint num, longint den);
    longint prod, quo;
    prod = comp * num;
    quo  = prod / den;
    if (prod < 0 && prod % den != 0) quo = quo - 1;
    return quo;
  endfunction

  function automatic si_pkg::si_out_t intersect_pair(si_pkg::si_in_t seg);
    longint          px, py, ex, ey, qx, qy, fx, fy;
    longint          rx, ry, sx, sy, dx, dy, den, tn, un;
    si_pkg::si_out_t res;
    res = MISS;
    px = seg.first_start_x;  py = seg.first_start_y;
    ex = seg.first_end_x;    ey = seg.first_end_y;
    qx = seg.second_start_x; qy = seg.second_start_y;
    fx = seg.second_end_x;   fy = seg.second_end_y;
    // boxes that only touch still count as overlapping
    if (lo2(px, ex) > hi2(qx, fx) || hi2(px, ex) < lo2(qx, fx) ||
        lo2(py, ey) > hi2(qy, fy) || hi2(py, ey) < lo2(qy, fy))
      return res;
    rx = ex - px; ry = ey - py;
    sx = fx - qx; sy = fy - qy;
    dx = qx - px; dy = qy - py;
    den = rx * sy - ry * sx;
    if (den == 0) return res;
    tn = dx * sy - dy * sx;
    un = dx * ry - dy * rx;
    if (den < 0) begin
      den = -den;
      tn  = -tn;
      un  = -un;
    end
    if (tn < 0 || tn > den || un < 0 || un > den) return res;
    res.hit     = 1'b1;
    res.cross_x = coord_t'(px + floor_scale(rx, tn, den));
    res.cross_y = coord_t'(py + floor_scale(ry, tn, den));
    res.t_frac  = frac_t'(((longint'(1) << si_pkg::PARAM_FRAC_BITS) * tn) / den);
    res.u_frac  = frac_t'(((longint'(1) << si_pkg::PARAM_FRAC_BITS) * un) / den);
    return res;
  endfunction

  function automatic si_pkg::si_in_t make_pair(int px, int py, int ex, int ey,
                                               int qx, int qy, int fx, int fy);
    si_pkg::si_in_t seg;
    seg.first_start_x  = coord_t'(px);
    seg.first_start_y  = coord_t'(py);
    seg.first_end_x    = coord_t'(ex);
    seg.first_end_y    = coord_t'(ey);
    seg.second_start_x = coord_t'(qx);
    seg.second_start_y = coord_t'(qy);
    seg.second_end_x   = coord_t'(fx);
    seg.second_end_y   = coord_t'(fy);
    return seg;
  endfunction

  function automatic si_pkg::si_out_t make_hit(int x, int y, int t, int u);
    si_pkg::si_out_t res;
    res.hit     = 1'b1;
    res.cross_x = coord_t'(x);
    res.cross_y = coord_t'(y);
    res.t_frac  = frac_t'(t);
    res.u_frac  = frac_t'(u);
    return res;
  endfunction

  function automatic coord_t jitter(longint base, int unsigned span);
    return coord_t'(base + longint'($urandom_range(2 * span)) - longint'(span));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0:       return {1'b1, {(si_pkg::COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(si_pkg::COORD_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic si_pkg::si_in_t random_pair();
    si_pkg::si_in_t seg;
    longint         bx, by, rx, ry;
    int unsigned    span;
    int             k;
    case ($urandom_range(3))
      0:       span = 8;
      1:       span = 64;
      2:       span = 1024;
      default: span = 16384;
    endcase
    bx = coord_t'($urandom);
    by = coord_t'($urandom);
    seg.first_start_x  = jitter(bx, span);
    seg.first_start_y  = jitter(by, span);
    seg.first_end_x    = jitter(bx, span);
    seg.first_end_y    = jitter(by, span);
    seg.second_start_x = jitter(bx, span);
    seg.second_start_y = jitter(by, span);
    seg.second_end_x   = jitter(bx, span);
    seg.second_end_y   = jitter(by, span);
    case ($urandom_range(9))
      0, 1, 2: seg = {$urandom, $urandom, $urandom, $urandom};
      3, 4, 5, 6: ;
      7: begin
        // shared endpoints land exactly on t or u of 0 or 1
        case ($urandom_range(2))
          0: begin
            seg.second_start_x = seg.first_start_x;
            seg.second_start_y = seg.first_start_y;
          end
          1: begin
            seg.second_end_x = seg.first_end_x;
            seg.second_end_y = seg.first_end_y;
          end
          default: begin
            seg.second_start_x = seg.first_end_x;
            seg.second_start_y = seg.first_end_y;
          end
        endcase
      end
      8: begin
        // parallel or collinear second segment, degenerate when k is zero
        rx = longint'($urandom_range(2 * span)) - longint'(span);
        ry = longint'($urandom_range(2 * span)) - longint'(span);
        seg.first_end_x = coord_t'(seg.first_start_x + rx);
        seg.first_end_y = coord_t'(seg.first_start_y + ry);
        if ($urandom_range(1) == 0) begin
          k = int'($urandom_range(4)) - 2;
          seg.second_start_x = coord_t'(seg.first_start_x + k * rx);
          seg.second_start_y = coord_t'(seg.first_start_y + k * ry);
        end
        k = int'($urandom_range(4)) - 2;
        seg.second_end_x = coord_t'(seg.second_start_x + k * rx);
        seg.second_end_y = coord_t'(seg.second_start_y + k * ry);
      end
      default: begin
        seg.first_start_x  = extreme_coord();
        seg.first_start_y  = extreme_coord();
        seg.first_end_x    = extreme_coord();
        seg.first_end_y    = extreme_coord();
        seg.second_start_x = extreme_coord();
        seg.second_start_y = extreme_coord();
        seg.second_end_x   = extreme_coord();
        seg.second_end_y   = extreme_coord();
      end
    endcase
    return seg;
  endfunction

  function automatic pair_row_t row(si_pkg::si_in_t seg, bit typed, si_pkg::si_out_t want);
    pair_row_t r;
    r.pair  = seg;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // hold the pair on the port until the block takes it, then log its expected crossing
  task automatic send_pair(si_pkg::si_in_t seg, bit typed, si_pkg::si_out_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= seg;
    @(posedge clk);
    while (busy) @(posedge clk);
    crossing_q.push_back(typed ? want : intersect_pair(seg));
  endtask

  initial begin
    directed_rows.push_back(row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(0, 0, 32, 32, 0, 32, 32, 0), 1'b1,
                                make_hit(16, 16, 32768, 32768)));
    directed_rows.push_back(row(make_pair(0, 0, 16, 0, 0, 0, 0, 16), 1'b1,
                                make_hit(0, 0, 0, 0)));
    directed_rows.push_back(row(make_pair(0, 0, 16, 0, 16, 16, 16, 0), 1'b1,
                                make_hit(16, 0, 65536, 65536)));
    directed_rows.push_back(row(make_pair(0, 0, 16, 16, 16, 16, 32, 0), 1'b1,
                                make_hit(16, 16, 65536, 0)));
    directed_rows.push_back(row(make_pair(0, 0, 64, 0, 32, 0, 32, 48), 1'b1,
                                make_hit(32, 0, 32768, 0)));
    directed_rows.push_back(row(make_pair(0, 0, 16, 16, 32, 0, 48, 16), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(0, 0, 32, 32, 0, 32, 8, 24), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(0, 0, 32, 0, 16, 0, 48, 0), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(0, 0, 32, 16, 0, 16, 32, 32), 1'b1, MISS));
    directed_rows.push_back(row(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768), 1'b0, MISS));
    directed_rows.push_back(row(make_pair(-32768, 0, 32767, 0,
                                          0, -32768, 0, 32767), 1'b0, MISS));
    directed_rows.push_back(row(make_pair(21845, -21846, -21846, 21845,
                                          -21846, -21846, 21845, 21845), 1'b0, MISS));
    directed_rows.push_back(row(make_pair(-100, -37, 55, 90, -80, 70, 33, -61), 1'b0, MISS));
    directed_rows.push_back(row(make_pair(50, -3, -7, 11, -20, -20, 30, 25), 1'b0, MISS));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);

    // the receiver cannot stall, so each phase only sets how often the sender idles
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = phase_idle[phase];
      for (int n = 0; n < RANDOM_PAIRS / PHASES; n++)
        send_pair(random_pair(), 1'b0, MISS);
    end
    start <= 1'b0;

    while (crossing_q.size() != 0) @(posedge clk);
    repeat (si_pkg::LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    si_pkg::si_out_t want;
    if (rst_n && out_valid) begin
      if (crossing_q.size() == 0) begin
        $error("result with no pair pending: hit %0b x %0d y %0d",
               out_data.hit, out_data.cross_x, out_data.cross_y);
        mismatch_count++;
      end else begin
        want = crossing_q.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_data.hit);
          mismatch_count++;
        end
        if (out_data.cross_x !== want.cross_x) begin
          $error("cross_x: expected %0d, got %0d", want.cross_x, out_data.cross_x);
          mismatch_count++;
        end
        if (out_data.cross_y !== want.cross_y) begin
          $error("cross_y: expected %0d, got %0d", want.cross_y, out_data.cross_y);
          mismatch_count++;
        end
        if (out_data.t_frac !== want.t_frac) begin
          $error("t_frac: expected %0d, got %0d", want.t_frac, out_data.t_frac);
          mismatch_count++;
        end
        if (out_data.u_frac !== want.u_frac) begin
          $error("u_frac: expected %0d, got %0d", want.u_frac, out_data.u_frac);
          mismatch_count++;
        end
      end
    end
  end

  // end the run if no transaction moves in either direction for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/si_pkg.sv
rtl/core/si_div.sv
rtl/core/si_front.sv
rtl/core/segment_intersection.sv
test/tb_segment_intersection.sv
